@@ design/gpu_pkg.sv @@
// shared types, register codes and pixel tables for the glyph pixel unpacker
package gpu_pkg;

  // input word: one packed byte of glyph data
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } in_word_t;

  // result word: one unpacked pixel
  typedef struct packed {
    logic [7:0] pixel_value;
    logic [5:0] column;
    logic [5:0] row;
    logic [7:0] gray_level;
    logic       opaque;
    logic       last_in_byte;
    logic       glyph_done;
  } out_word_t;

  // queue status seen by the neighbors of a queue
  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_DEPTH_MODE   = 2'd0,
    CFG_GLYPH_WIDTH  = 2'd1,
    CFG_GLYPH_HEIGHT = 2'd2
  } cfg_index_t;

  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned DIM_W      = 7;

  // masks of the top field of a byte, per depth mode
  localparam logic [3:0][7:0] FIELD_TOP_MASK = {8'hFF, 8'hF0, 8'hC0, 8'h80};
  // grey step per level, per depth mode
  localparam logic [3:0][7:0] LEVEL_STEP     = {8'd1, 8'd17, 8'd85, 8'd255};

  // value of the top field of a byte, right aligned
  function automatic logic [7:0] field_value(input logic [7:0] bits, input logic [1:0] mode);
    logic [7:0] masked;
    logic [2:0] sh;
    masked = bits & FIELD_TOP_MASK[mode];
    sh     = 3'(8 - (1 << mode));
    return masked >> sh;
  endfunction

  // inverted grey level, zero is white
  function automatic logic [7:0] gray_of(input logic [7:0] val, input logic [1:0] mode);
    logic [15:0] prod;
    prod = 16'(val) * 16'(LEVEL_STEP[mode]);
    return 8'(8'hFF - prod[7:0]);
  endfunction

endpackage

@@ design/glyph_pixel_unpacker.sv @@
// top level of the glyph pixel unpacker: registers, input queue, unpacker, result queue
//
//  channel   direction  handshake                 word
//  input     in         push / full               item   (data_byte, end_of_data)
//  result    out        empty / pop               result (pixel and position)
//  config    in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// one result word per cycle while the input queue holds a byte and the result queue has room;
// a byte gives 8 >> depth_mode pixels, fewer when the glyph fills or ends early
// a two-entry queue on each side lets the input and result sides stall on their own
// the unpacker stalls only while the result queue is full or the input queue is empty
// rst is synchronous: empties both queues, clears the position counters, loads
// depth_mode 0 and an 8 by 8 glyph
module glyph_pixel_unpacker #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  // input channel
  input  logic                              push,
  output logic                              full,
  input  gpu_pkg::in_word_t                 item,
  // result channel
  output logic                              empty,
  input  logic                              pop,
  output gpu_pkg::out_word_t                result,
  // configuration channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [gpu_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam logic [8:0] MaxW = 9'(MAX_WIDTH);
  localparam logic [8:0] MaxH = 9'(MAX_HEIGHT);

  // configuration registers
  logic [1:0]                depth_mode;
  logic [gpu_pkg::DIM_W-1:0] glyph_width;
  logic [gpu_pkg::DIM_W-1:0] glyph_height;
  logic [8:0]                width_eff;
  logic [8:0]                height_eff;

  gpu_pkg::in_word_t  head;
  gpu_pkg::qstat_t    in_stat;
  gpu_pkg::qstat_t    out_stat;
  gpu_pkg::out_word_t pixel;
  logic               in_pop;
  logic               out_push;

  // registers may change at any time the channel is valid
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_mode   <= 2'd0;
      glyph_width  <= gpu_pkg::DIM_W'(8);
      glyph_height <= gpu_pkg::DIM_W'(8);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gpu_pkg::CFG_DEPTH_MODE:   depth_mode   <= cfg_data[1:0];
        gpu_pkg::CFG_GLYPH_WIDTH:  glyph_width  <= cfg_data[gpu_pkg::DIM_W-1:0];
        gpu_pkg::CFG_GLYPH_HEIGHT: glyph_height <= cfg_data[gpu_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, anything above the maximum acts as the maximum
  always_comb begin
    priority if (glyph_width == '0) begin
      width_eff = 9'd1;
    end else if (9'(glyph_width) > MaxW) begin
      width_eff = MaxW;
    end else begin
      width_eff = 9'(glyph_width);
    end
    priority if (glyph_height == '0) begin
      height_eff = 9'd1;
    end else if (9'(glyph_height) > MaxH) begin
      height_eff = MaxH;
    end else begin
      height_eff = 9'(glyph_height);
    end
  end

  // front: input bytes wait here until the unpacker gets to them
  gpu_fifo #(
    .T     (gpu_pkg::in_word_t),
    .DEPTH (2)
  ) u_in_q (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (item),
    .pop     (in_pop),
    .rd_data (head),
    .stat    (in_stat)
  );

  // back: one pixel per cycle from the head byte, unless the input queue is empty or the result queue is full
  gpu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .depth_mode (depth_mode),
    .width_eff  (width_eff),
    .height_eff (height_eff),
    .head       (head),
    .in_stat    (in_stat),
    .in_pop     (in_pop),
    .out_stat   (out_stat),
    .out_push   (out_push),
    .pixel      (pixel)
  );

  // result words wait here until popped
  gpu_fifo #(
    .T     (gpu_pkg::out_word_t),
    .DEPTH (2)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .push    (out_push),
    .wr_data (pixel),
    .pop     (pop),
    .rd_data (result),
    .stat    (out_stat)
  );

  assign full  = in_stat.full;
  assign empty = out_stat.empty;

  // the unpacker never writes a full result queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    out_push |-> !out_stat.full)
    else $error("pixel written into a full result queue");

  // the head byte is released only together with a pixel
  a_pop_with_pixel: assert property (@(posedge clk) disable iff (rst)
    in_pop |-> (out_push && !in_stat.empty))
    else $error("input byte released without its last pixel");

  // the end of a glyph always closes the byte
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (!result.glyph_done || result.last_in_byte))
    else $error("glyph end without last pixel of byte");

endmodule

@@ design/gpu_fifo.sv @@
// small first-in first-out queue between the parts of the unpacker
module gpu_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  T                wr_data,
  input  logic            pop,
  output T                rd_data,
  output gpu_pkg::qstat_t stat
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  T                mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            push_ok;
  logic            pop_ok;

  assign stat.empty = (count == '0);
  assign stat.full  = (count == FullCnt);
  assign push_ok    = push && !stat.full;
  assign pop_ok     = pop && !stat.empty;
  assign rd_data    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : PtrW'(wr_ptr + 1'b1);
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : PtrW'(rd_ptr + 1'b1);
      end
      if (push_ok && !pop_ok) begin
        count <= CntW'(count + 1'b1);
      end else if (pop_ok && !push_ok) begin
        count <= CntW'(count - 1'b1);
      end
    end
  end

endmodule

@@ design/gpu_back.sv @@
// back end: walks the fields of the head byte and tracks the glyph position
module gpu_back (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        depth_mode,
  input  logic [8:0]        width_eff,
  input  logic [8:0]        height_eff,
  input  gpu_pkg::in_word_t head,
  input  gpu_pkg::qstat_t   in_stat,
  output logic              in_pop,
  input  gpu_pkg::qstat_t   out_stat,
  output logic              out_push,
  output gpu_pkg::out_word_t pixel
);

  logic [2:0] field_idx;
  logic [2:0] field_idx_next;
  logic [5:0] col_count;
  logic [5:0] col_count_next;
  logic [5:0] row_count;
  logic [5:0] row_count_next;
  logic [2:0] shamt;
  logic [7:0] shifted;
  logic [7:0] val;
  logic       last_field;
  logic       col_wrap;
  logic       row_wrap;
  logic       done;
  logic       last;

  assign shamt      = 3'(field_idx << depth_mode);
  assign shifted    = 8'(head.data_byte << shamt);
  assign val        = gpu_pkg::field_value(shifted, depth_mode);
  assign last_field = (field_idx == 3'(3'd7 >> depth_mode));
  assign col_wrap   = (9'(col_count) + 9'd1) >= width_eff;
  assign row_wrap   = (9'(row_count) + 9'd1) >= height_eff;
  // glyph filled, or early end at the last field of a flagged byte
  assign done       = (col_wrap && row_wrap) || (last_field && head.end_of_data);
  assign last       = last_field || done;

  assign out_push = !in_stat.empty && !out_stat.full;
  assign in_pop   = out_push && last;

  assign pixel.pixel_value  = val;
  assign pixel.column       = col_count;
  assign pixel.row          = row_count;
  assign pixel.gray_level   = gpu_pkg::gray_of(val, depth_mode);
  assign pixel.opaque       = (val != 8'd0);
  assign pixel.last_in_byte = last;
  assign pixel.glyph_done   = done;

  always_comb begin
    field_idx_next = field_idx;
    col_count_next = col_count;
    row_count_next = row_count;
    if (out_push) begin
      field_idx_next = last ? 3'd0 : 3'(field_idx + 3'd1);
      priority if (done) begin
        col_count_next = '0;
        row_count_next = '0;
      end else if (col_wrap) begin
        col_count_next = '0;
        row_count_next = 6'(row_count + 6'd1);
      end else begin
        col_count_next = 6'(col_count + 6'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_idx <= '0;
      col_count <= '0;
      row_count <= '0;
    end else begin
      field_idx <= field_idx_next;
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

endmodule

@@ test/tb.sv @@
// self-checking testbench of the glyph pixel unpacker: directed and random bytes, random stalls
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_W = 64;
  localparam int unsigned MAX_H = 64;
  // cycles without any accepted word before the run is declared hung
  localparam int unsigned HANG_LIMIT = 5000;
  // cycles to keep popping after the last expected pixel, to catch strays
  localparam int unsigned DRAIN_CYCLES = 40;
  // receiver hold-off that lets both queues fill and stall the input side
  localparam int unsigned SQUEEZE_CYCLES = 300;
  localparam int unsigned RANDOM_BYTES = 350;

  // expected pixel stream of the unpacker, kept in step with the dut registers
  class pixel_tracker;
    logic [1:0] depth;
    logic [6:0] width;
    logic [6:0] height;
    int unsigned col;
    int unsigned row;
    gpu_pkg::out_word_t pending_pixels[$];
    int unsigned errors;

    function new();
      depth  = 2'd0;
      width  = 7'd8;
      height = 7'd8;
      col    = 0;
      row    = 0;
      errors = 0;
    endfunction

    function void set_reg(gpu_pkg::cfg_index_t idx, logic [7:0] d);
      case (idx)
        gpu_pkg::CFG_DEPTH_MODE:   depth  = d[1:0];
        gpu_pkg::CFG_GLYPH_WIDTH:  width  = d[6:0];
        gpu_pkg::CFG_GLYPH_HEIGHT: height = d[6:0];
        default: ;
      endcase
    endfunction

    // zero acts as one, anything past the maximum acts as the maximum
    function int unsigned dim_bound(logic [6:0] v, int unsigned top);
      if (v == 0) return 1;
      if (v > top) return top;
      return v;
    endfunction

    // expand one accepted byte into the pixels it must produce
    function void take_byte(gpu_pkg::in_word_t w);
      int unsigned bpp, per, step, wlim, hlim, val;
      bit done, last;
      gpu_pkg::out_word_t px;
      bpp  = 1 << depth;
      per  = 8 >> depth;
      step = 255 / ((1 << bpp) - 1);
      wlim = dim_bound(width, MAX_W);
      hlim = dim_bound(height, MAX_H);
      for (int unsigned k = 0; k < per; k++) begin
        val  = (w.data_byte >> (8 - bpp * (k + 1))) & ((1 << bpp) - 1);
        done = 1'b0;
        last = (k + 1 == per);
        px.pixel_value = val[7:0];
        px.column      = col[5:0];
        px.row         = row[5:0];
        px.gray_level  = 8'(255 - val * step);
        px.opaque      = (val != 0);
        // walk the glyph row by row, wrap at the last pixel
        if (col + 1 >= wlim) begin
          col = 0;
          if (row + 1 >= hlim) begin
            row  = 0;
            done = 1'b1;
          end else begin
            row = row + 1;
          end
        end else begin
          col = col + 1;
        end
        // early end of glyph on the last pixel of a flagged byte
        if (last && w.end_of_data && !done) begin
          col  = 0;
          row  = 0;
          done = 1'b1;
        end
        // a filled glyph drops the rest of the byte
        if (done) last = 1'b1;
        px.last_in_byte = last;
        px.glyph_done   = done;
        pending_pixels.push_back(px);
        if (last) break;
      end
    endfunction

    function void field_diff(string name, logic [7:0] want_v, logic [7:0] got_v);
      if (got_v !== want_v)
        $display("%0t: %s expected %0d got %0d", $time, name, want_v, got_v);
    endfunction

    // compare one popped pixel with the oldest expected one
    function void match_pixel(gpu_pkg::out_word_t got);
      gpu_pkg::out_word_t want;
      if (pending_pixels.size() == 0) begin
        errors++;
        $display("%0t: pixel with none expected, expected nothing got %h", $time, got);
        return;
      end
      want = pending_pixels.pop_front();
      if (got !== want) begin
        errors++;
        field_diff("pixel_value", want.pixel_value, got.pixel_value);
        field_diff("column", 8'(want.column), 8'(got.column));
        field_diff("row", 8'(want.row), 8'(got.row));
        field_diff("gray_level", want.gray_level, got.gray_level);
        field_diff("opaque", 8'(want.opaque), 8'(got.opaque));
        field_diff("last_in_byte", 8'(want.last_in_byte), 8'(got.last_in_byte));
        field_diff("glyph_done", 8'(want.glyph_done), 8'(got.glyph_done));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push;
  logic full;
  gpu_pkg::in_word_t item;
  logic empty;
  logic pop;
  gpu_pkg::out_word_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [gpu_pkg::CFG_DATA_W-1:0] cfg_data;

  pixel_tracker book = new();

  // stall control of the driving processes, rx_hold shared by sender and receiver, and the hang count
  bit tx_burst;
  bit tx_steady;
  bit rx_burst;
  int unsigned rx_hold;
  int unsigned idle_cycles;

  always #1 clk = ~clk;

  glyph_pixel_unpacker #(
    .MAX_WIDTH(MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .item(item),
    .empty(empty),
    .pop(pop),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // gap before the next byte: stretches of back-to-back words, otherwise random idle gaps
  function automatic int unsigned tx_gap();
    if ($urandom_range(0, 15) == 0) tx_burst = !tx_burst;
    if (tx_burst || tx_steady) return 0;
    return $urandom_range(0, 12);
  endfunction

  // offer one byte and hold it until the dut takes it; push stays high when no gap follows
  task automatic send_byte(logic [7:0] d, logic eod);
    int unsigned gap;
    gpu_pkg::in_word_t w;
    gap = tx_gap();
    w.data_byte   = d;
    w.end_of_data = eod;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    item <= w;
    @(posedge clk);
    while (full) @(posedge clk);
    book.take_byte(w);
  endtask

  // register writes only once every expected pixel is out, so the unpacker is idle
  task automatic configure(logic [2:0] sel, logic [7:0] d, logic [7:0] w, logic [7:0] h);
    gpu_pkg::cfg_index_t idx[3];
    logic [7:0] val[3];
    idx = '{gpu_pkg::CFG_DEPTH_MODE, gpu_pkg::CFG_GLYPH_WIDTH, gpu_pkg::CFG_GLYPH_HEIGHT};
    val = '{d, w, h};
    push <= 1'b0;
    while (book.pending_pixels.size() != 0) @(posedge clk);
    for (int i = 0; i < 3; i++) begin
      if (sel[i]) begin
        cfg_valid <= 1'b1;
        cfg_index <= idx[i];
        cfg_data  <= val[i];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        book.set_reg(idx[i], val[i]);
      end
    end
    cfg_valid <= 1'b0;
  endtask

  // glyph dimension: mostly small so glyphs end often, sometimes the extremes or raw data
  function automatic logic [7:0] pick_dim();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return 8'($urandom_range(1, 8));
    if (r < 7) return 8'($urandom_range(1, 64));
    if (r < 8) return ($urandom_range(0, 1) != 0) ? 8'd64 : 8'd1;
    return 8'($urandom_range(0, 255));
  endfunction

  // a run of glyph bytes under fresh settings; squeeze holds off the receiver meanwhile
  task automatic random_phase(bit squeeze, inout int unsigned sent);
    int unsigned n;
    logic [2:0] sel;
    n = squeeze ? 40 : $urandom_range(10, 30);
    sel = 3'($urandom_range(1, 7));
    configure(sel, 8'($urandom_range(0, 255)), pick_dim(), pick_dim());
    if (squeeze) begin
      rx_hold   = SQUEEZE_CYCLES;
      tx_steady = 1'b1;
    end
    repeat (n) begin
      send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 11) == 0);
      sent++;
    end
    tx_steady = 1'b0;
  endtask

  // receiver: pops with random gaps, one long hold-off on request
  initial begin
    int unsigned gap;
    wait (rst == 1'b0);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
      gap = rx_burst ? 0 : $urandom_range(0, 12);
      if (rx_hold > 0) begin
        gap     = gap + rx_hold;
        rx_hold = 0;
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      book.match_pixel(result);
    end
  end

  // hang detection: any accepted word on any channel resets the count
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= HANG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, HANG_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int unsigned sent;
    push      <= 1'b0;
    item      <= '0;
    pop       <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= gpu_pkg::CFG_DEPTH_MODE;
    cfg_data  <= '0;
    tx_burst  = 1'b0;
    tx_steady = 1'b0;
    rx_burst  = 1'b0;
    rx_hold   = 0;
    sent      = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset settings: one bit per pixel, 8 by 8; all-ones, all-zeros, single bits, early end
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hA5, 1'b1);

    // two bits per pixel, 3 by 1: the glyph fills in the middle of a byte
    configure(3'b111, 8'd1, 8'd3, 8'd1);
    send_byte(8'hE4, 1'b0);
    send_byte(8'h1B, 1'b0);

    // four bits per pixel, zero width acts as one, height past the maximum is clamped
    configure(3'b111, 8'd2, 8'd0, 8'd127);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h0F, 1'b0);

    // eight bits per pixel at the largest glyph, then an early end
    configure(3'b111, 8'd3, 8'd64, 8'd64);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);

    // width shrinks below the current column in the middle of a glyph
    configure(3'b111, 8'd0, 8'd20, 8'd4);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hC3, 1'b0);
    configure(3'b010, 8'd0, 8'd5, 8'd0);
    send_byte(8'h96, 1'b0);
    send_byte(8'h3C, 1'b0);

    // one-pixel glyph: every pixel ends a glyph
    configure(3'b111, 8'd2, 8'd1, 8'd1);
    send_byte(8'h3C, 1'b0);

    // random settings and bytes, one phase with the receiver held off
    while (sent < RANDOM_BYTES) random_phase(sent >= 100 && sent < 130, sent);
    push <= 1'b0;

    while (book.pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (book.errors == 0 && book.pending_pixels.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
